// File: rtl/core/rrbl_pkg.sv
// Package: shared constants and controller types for the bit-flip locator.
package rrbl_pkg;

    // Row geometry
    localparam int COLUMNS        = 32;
    localparam int WORDS_PER_READ = 4;
    localparam int CHANNEL_HALVES = 2;
    localparam int GROUP_WORDS    = WORDS_PER_READ * CHANNEL_HALVES;
    localparam int ROW_WORDS      = COLUMNS * GROUP_WORDS;
    localparam int CHECKED_BITS   = COLUMNS * WORDS_PER_READ * 64;
    localparam int COUNT_CAP      = (CHECKED_BITS > 16383) ? 16383 : CHECKED_BITS;

    // Field widths
    localparam int DATA_W  = 64;
    localparam int BIT_W   = 6;
    localparam int INDEX_W = 13;
    localparam int TOTAL_W = 14;
    localparam int COL_W   = 5;
    localparam int WORD_W  = 2;
    localparam int HALF_W  = 1;
    localparam int POS_W   = COL_W + HALF_W + WORD_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTE     = 2'd0,
        REG_CHANNEL_HALF     = 2'd1,
        REG_COLUMN_FILTER_ON = 2'd2,
        REG_CHOSEN_COLUMN    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic has_work;
        logic final_emit;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/row_readback_bitflip_locator.sv
// Results of a word go from the pending-work register through the output register.
// One word per cycle when it gives no result; otherwise new words wait until its last
// result; one per cycle from the lowest-set-bit serializer as m_ready allows.
// The output register lets the next word be taken while the last result waits.
// Reset (aresetn, synchronous, active low) clears config, row position and flip count.
module row_readback_bitflip_locator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rrbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrbl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rrbl_pkg::DATA_W-1:0]     s_data_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_is_flip,
    output logic [rrbl_pkg::INDEX_W-1:0]    m_flip_index,
    output logic                            m_row_end,
    output logic                            m_any_flip,
    output logic [rrbl_pkg::TOTAL_W-1:0]    m_flip_total,
    output logic                            m_last
);

    rrbl_pkg::dp_cmd_t    cmd;
    rrbl_pkg::dp_status_t status;

    // Sequencer
    rrbl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Compare and result datapath
    rrbl_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_data_word  (s_data_word),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_flip    (m_is_flip),
        .m_flip_index (m_flip_index),
        .m_row_end    (m_row_end),
        .m_any_flip   (m_any_flip),
        .m_flip_total (m_flip_total),
        .m_last       (m_last)
    );

endmodule

// File: rtl/core/rrbl_datapath.sv
// Datapath: config registers, compare, flip serializer, counters and output register.
module rrbl_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rrbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrbl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [rrbl_pkg::DATA_W-1:0]   s_data_word,
    input  rrbl_pkg::dp_cmd_t             cmd,
    output rrbl_pkg::dp_status_t          status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_is_flip,
    output logic [rrbl_pkg::INDEX_W-1:0]  m_flip_index,
    output logic                          m_row_end,
    output logic                          m_any_flip,
    output logic [rrbl_pkg::TOTAL_W-1:0]  m_flip_total,
    output logic                          m_last
);

    // Configuration registers
    logic [7:0]                    pattern_byte_reg;
    logic                          channel_half_reg;
    logic                          column_filter_on_reg;
    logic [rrbl_pkg::COL_W-1:0]    chosen_column_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_byte_reg     <= '0;
            channel_half_reg     <= 1'b0;
            column_filter_on_reg <= 1'b0;
            chosen_column_reg    <= '0;
        end else if (cfg_we) begin
            case (rrbl_pkg::cfg_reg_t'(cfg_index))
                rrbl_pkg::REG_PATTERN_BYTE:     pattern_byte_reg     <= cfg_data;
                rrbl_pkg::REG_CHANNEL_HALF:     channel_half_reg     <= cfg_data[0];
                rrbl_pkg::REG_COLUMN_FILTER_ON: column_filter_on_reg <= cfg_data[0];
                rrbl_pkg::REG_CHOSEN_COLUMN:
                    chosen_column_reg <= cfg_data[rrbl_pkg::COL_W-1:0];
                default: ;
            endcase
        end
    end

    // Position decode and compare of the incoming word
    logic [rrbl_pkg::POS_W-1:0]   pos_reg;
    logic [rrbl_pkg::COL_W-1:0]   in_column;
    logic                         in_half;
    logic [rrbl_pkg::WORD_W-1:0]  in_word;
    logic                         in_closing;
    logic                         in_checked;
    logic [rrbl_pkg::DATA_W-1:0]  in_diff;

    assign in_column  = pos_reg[rrbl_pkg::POS_W-1 -: rrbl_pkg::COL_W];
    assign in_half    = pos_reg[rrbl_pkg::WORD_W];
    assign in_word    = pos_reg[rrbl_pkg::WORD_W-1:0];
    assign in_closing = (pos_reg == rrbl_pkg::POS_W'(rrbl_pkg::ROW_WORDS - 1));
    assign in_checked = (in_half == channel_half_reg) &&
                        (!column_filter_on_reg || (in_column == chosen_column_reg));
    assign in_diff    = in_checked ? (s_data_word ^ {8{pattern_byte_reg}}) : '0;

    // Pending work of the accepted word
    logic [rrbl_pkg::DATA_W-1:0]  diff_reg;
    logic [rrbl_pkg::INDEX_W-1:0] base_reg;
    logic                         closing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.load) begin
            pos_reg <= in_closing ? '0 : pos_reg + 1'b1;
        end
    end

    // Lowest set bit of the pending difference
    logic [rrbl_pkg::DATA_W-1:0]  diff_rest;
    logic [rrbl_pkg::DATA_W-1:0]  low_onehot;
    logic [rrbl_pkg::BIT_W-1:0]   low_bit;
    logic                         summary;

    assign diff_rest  = diff_reg & (diff_reg - 1'b1);
    assign low_onehot = diff_reg & ~diff_rest;
    assign summary    = (diff_reg == '0);

    always_comb begin
        low_bit = '0;
        for (int b = 0; b < rrbl_pkg::DATA_W; b++) begin
            if (low_onehot[b]) begin
                low_bit = low_bit | rrbl_pkg::BIT_W'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            diff_reg    <= in_diff;
            base_reg    <= {in_column, in_word, {rrbl_pkg::BIT_W{1'b0}}};
            closing_reg <= in_closing;
        end else if (cmd.emit) begin
            diff_reg <= diff_rest;
        end
    end

    // Saturating flip counter
    logic [rrbl_pkg::TOTAL_W-1:0] count_reg;
    logic [rrbl_pkg::TOTAL_W-1:0] count_next;
    logic                         emit_last;

    assign emit_last = summary || (diff_rest == '0);

    always_comb begin
        count_next = count_reg;
        if (!summary && (count_reg < rrbl_pkg::TOTAL_W'(rrbl_pkg::COUNT_CAP))) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.emit) begin
            count_reg <= (closing_reg && emit_last) ? '0 : count_next;
        end
    end

    // Output register
    logic                         m_valid_reg;
    logic                         is_flip_reg;
    logic [rrbl_pkg::INDEX_W-1:0] flip_index_reg;
    logic                         row_end_reg;
    logic                         any_flip_reg;
    logic [rrbl_pkg::TOTAL_W-1:0] flip_total_reg;
    logic                         last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            is_flip_reg    <= !summary;
            flip_index_reg <= summary ? '0 : (base_reg | rrbl_pkg::INDEX_W'(low_bit));
            row_end_reg    <= closing_reg && emit_last;
            any_flip_reg   <= (count_next != '0);
            flip_total_reg <= count_next;
            last_reg       <= emit_last;
        end
    end

    assign status.has_work   = (in_diff != '0) || in_closing;
    assign status.final_emit = emit_last;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_is_flip    = is_flip_reg;
    assign m_flip_index = flip_index_reg;
    assign m_row_end    = row_end_reg;
    assign m_any_flip   = any_flip_reg;
    assign m_flip_total = flip_total_reg;
    assign m_last       = last_reg;

endmodule

// File: rtl/core/rrbl_ctrl.sv
// Controller: takes one request at a time and sequences its result emission.
module rrbl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rrbl_pkg::dp_status_t status,
    output rrbl_pkg::dp_cmd_t    cmd
);

    rrbl_pkg::state_t state_reg;
    rrbl_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrbl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            rrbl_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && status.has_work) begin
                    state_next = rrbl_pkg::ST_EMIT;
                end
            end
            rrbl_pkg::ST_EMIT: begin
                cmd.emit = status.out_free;
                if (status.out_free && status.final_emit) begin
                    state_next = rrbl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrbl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: tb/row_readback_bitflip_locator_checker.sv
// Checker for the bit-flip locator: tracks the row, predicts every flip report and compares.
`timescale 1ns / 1ps

module row_readback_bitflip_locator_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rrbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrbl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [rrbl_pkg::DATA_W-1:0]     s_data_word,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_is_flip,
    input  logic [rrbl_pkg::INDEX_W-1:0]    m_flip_index,
    input  logic                            m_row_end,
    input  logic                            m_any_flip,
    input  logic [rrbl_pkg::TOTAL_W-1:0]    m_flip_total,
    input  logic                            m_last,
    output int                              reports_due,
    output int                              mismatch_cnt
);
    import rrbl_pkg::*;

    typedef struct packed {
        logic               is_flip;
        logic [INDEX_W-1:0] flip_index;
        logic               row_end;
        logic               any_flip;
        logic [TOTAL_W-1:0] flip_total;
        logic               last;
    } flip_report_t;

    // Shadow of the register file
    logic [7:0]       pattern_q;
    logic             half_q;
    logic             filter_q;
    logic [COL_W-1:0] column_q;

    // Row progress
    int unsigned      word_pos;
    int unsigned      flips_in_row;

    flip_report_t     flip_reports_q[$];

    // Works out the reports one readback word causes and queues them
    task automatic locate_flips(input logic [DATA_W-1:0] word);
        logic [DATA_W-1:0] diff;
        int unsigned       col;
        int unsigned       grp_half;
        int unsigned       grp_word;
        int unsigned       nflips;
        int unsigned       seen;
        logic              closing;
        logic              checked;
        flip_report_t      rep;
        diff     = word ^ {8{pattern_q}};
        col      = word_pos / GROUP_WORDS;
        grp_half = (word_pos % GROUP_WORDS) / WORDS_PER_READ;
        grp_word = word_pos % WORDS_PER_READ;
        closing  = (word_pos == ROW_WORDS - 1);
        checked  = (grp_half == half_q) && (!filter_q || col == column_q);
        if (checked && diff != '0) begin
            // one report per differing bit, lowest first
            nflips = $countones(diff);
            seen   = 0;
            for (int b = 0; b < DATA_W; b++) begin
                if (diff[b]) begin
                    seen++;
                    if (flips_in_row < COUNT_CAP)
                        flips_in_row++;
                    rep.is_flip    = 1'b1;
                    rep.flip_index = INDEX_W'(col * 256 + grp_word * 64 + b);
                    rep.row_end    = closing && (seen == nflips);
                    rep.any_flip   = (flips_in_row != 0);
                    rep.flip_total = TOTAL_W'(flips_in_row);
                    rep.last       = (seen == nflips);
                    flip_reports_q.insert(flip_reports_q.size(), rep);
                end
            end
        end else if (closing) begin
            // row summary
            rep.is_flip    = 1'b0;
            rep.flip_index = '0;
            rep.row_end    = 1'b1;
            rep.any_flip   = (flips_in_row != 0);
            rep.flip_total = TOTAL_W'(flips_in_row);
            rep.last       = 1'b1;
            flip_reports_q.insert(flip_reports_q.size(), rep);
        end
        if (closing) begin
            word_pos     = 0;
            flips_in_row = 0;
        end else begin
            word_pos++;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        flip_report_t want;
        if (!aresetn) begin
            pattern_q    = '0;
            half_q       = 1'b0;
            filter_q     = 1'b0;
            column_q     = '0;
            word_pos     = 0;
            flips_in_row = 0;
            mismatch_cnt = 0;
            flip_reports_q.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_PATTERN_BYTE:     pattern_q = cfg_data;
                    REG_CHANNEL_HALF:     half_q    = cfg_data[0];
                    REG_COLUMN_FILTER_ON: filter_q  = cfg_data[0];
                    REG_CHOSEN_COLUMN:    column_q  = cfg_data[COL_W-1:0];
                    default: ;
                endcase
            end
            // result side: oldest expectation first
            if (m_valid && m_ready) begin
                if (flip_reports_q.size() == 0) begin
                    mismatch_cnt++;
                    $error("unexpected report, flip_index %0d", m_flip_index);
                end else begin
                    want = flip_reports_q.pop_front();
                    check_field("is_flip", 16'(want.is_flip), 16'(m_is_flip));
                    check_field("flip_index", 16'(want.flip_index), 16'(m_flip_index));
                    check_field("row_end", 16'(want.row_end), 16'(m_row_end));
                    check_field("any_flip", 16'(want.any_flip), 16'(m_any_flip));
                    check_field("flip_total", 16'(want.flip_total), 16'(m_flip_total));
                    check_field("last", 16'(want.last), 16'(m_last));
                end
            end
            // request side
            if (s_valid && s_ready)
                locate_flips(s_data_word);
        end
        reports_due <= flip_reports_q.size();
    end

endmodule

// File: tb/row_readback_bitflip_locator_test.sv
// Testbench top: feeds readback rows and register writes, paces the result side, gives the verdict.
`timescale 1ns / 1ps

module row_readback_bitflip_locator_test;
    import rrbl_pkg::*;

    localparam int IDLE_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int SETTLE_CYC = 4;      // pipeline depth margin before a register write
    localparam int LONG_HOLD  = 300;    // opening receiver hold-off
    localparam int SAT_WORDS  = 17 * GROUP_WORDS;   // enough fully flipped words to saturate

    typedef enum int {
        WK_CLEAN, WK_SPARSE, WK_NOISE, WK_INVERT, WK_ZERO, WK_ONES
    } word_kind_t;

    typedef enum int {
        PACE_OPEN, PACE_MOSTLY, PACE_HALF, PACE_SPARSE, PACE_STOP
    } pace_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_data_word = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_is_flip;
    logic [INDEX_W-1:0]    m_flip_index;
    logic                  m_row_end;
    logic                  m_any_flip;
    logic [TOTAL_W-1:0]    m_flip_total;
    logic                  m_last;

    int                    reports_due;
    int                    mismatch_cnt;
    int                    quiet_cycles = 0;

    // Stimulus-side view of the row and the registers, used to shape the words
    int unsigned           feed_pos   = 0;
    int unsigned           burst_left = 0;
    logic [7:0]            cur_pattern;

    row_readback_bitflip_locator i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_flip    (m_is_flip),
        .m_flip_index (m_flip_index),
        .m_row_end    (m_row_end),
        .m_any_flip   (m_any_flip),
        .m_flip_total (m_flip_total),
        .m_last       (m_last)
    );

    row_readback_bitflip_locator_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_flip    (m_is_flip),
        .m_flip_index (m_flip_index),
        .m_row_end    (m_row_end),
        .m_any_flip   (m_any_flip),
        .m_flip_total (m_flip_total),
        .m_last       (m_last),
        .reports_due  (reports_due),
        .mismatch_cnt (mismatch_cnt)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: too long without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] pick_pattern();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic word_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)      return WK_CLEAN;
        else if (r < 65) return WK_SPARSE;
        else if (r < 80) return WK_NOISE;
        else if (r < 88) return WK_INVERT;
        else if (r < 94) return WK_ZERO;
        else             return WK_ONES;
    endfunction

    function automatic logic [DATA_W-1:0] make_word(input word_kind_t kind,
                                                     input logic [7:0] pat);
        logic [DATA_W-1:0] w;
        w = {8{pat}};
        case (kind)
            WK_SPARSE: repeat ($urandom_range(1, 3)) w[$urandom_range(0, DATA_W-1)] ^= 1'b1;
            WK_NOISE:  w = {$urandom, $urandom};
            WK_INVERT: w = ~w;
            WK_ZERO:   w = '0;
            WK_ONES:   w = '1;
            default: ;
        endcase
        return w;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    // Write all four registers; unused upper bits of the flag and column registers get junk
    task automatic set_config(input logic [7:0] pat, input logic half, input logic filt,
                              input logic [COL_W-1:0] col);
        write_reg(REG_PATTERN_BYTE, pat);
        write_reg(REG_CHANNEL_HALF, {7'($urandom), half});
        write_reg(REG_COLUMN_FILTER_ON, {7'($urandom), filt});
        write_reg(REG_CHOSEN_COLUMN, {3'($urandom), col});
        cfg_we      <= 1'b0;
        cur_pattern  = pat;
    endtask

    // Offer one word; bursts of random length with random gaps between them
    task automatic push_word(input logic [DATA_W-1:0] word);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid     <= 1'b1;
        s_data_word <= word;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        feed_pos = (feed_pos + 1) % ROW_WORDS;
    endtask

    // Called right after an accepted request: wait until every report is in
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reports_due != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Result side pacing
    initial begin : result_pace
        pace_t       mode;
        int unsigned run;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        // long hold-off while words keep coming, so the block backs up
        repeat (LONG_HOLD) @(posedge aclk);
        forever begin
            mode = pace_t'($urandom_range(0, 4));
            run  = $urandom_range(16, 160);
            repeat (run) begin
                case (mode)
                    PACE_OPEN:   m_ready <= 1'b1;
                    PACE_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    PACE_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    PACE_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= 1'b0;
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_len;
        int unsigned near_col;
        logic        closing_phase;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Column 0: match, all 64 bits flipped, lowest and highest bit, other half ignored
        set_config(8'h00, 1'b0, 1'b0, 5'd0);
        push_word(64'h0);
        push_word('1);
        push_word(64'h1);
        push_word(64'h8000_0000_0000_0000);
        push_word('1);
        push_word({$urandom, $urandom});
        push_word(64'h0);
        push_word(64'hDEAD_BEEF_0123_4567);
        settle();

        // Column 1, second half, filter on it
        set_config(8'hFF, 1'b1, 1'b1, 5'd1);
        repeat (4) push_word(64'h0);
        push_word('1);
        push_word(64'h0);
        push_word(~64'h20);
        push_word(64'hAAAA_AAAA_AAAA_AAAA);
        settle();

        // Column 2 filtered out: nothing reported whatever the data
        set_config(8'hA5, 1'b1, 1'b1, 5'd31);
        push_word({8{8'hA5}});
        push_word(64'h0);
        push_word('1);
        push_word({$urandom, $urandom});
        push_word({8{8'hA5}});
        push_word(64'h0);
        push_word('1);
        push_word({$urandom, $urandom});
        settle();

        // Rest of the first row in phases of random settings; it closes on a summary
        while (feed_pos != 0) begin
            phase_len = $urandom_range(8, 40);
            if (phase_len > ROW_WORDS - feed_pos)
                phase_len = ROW_WORDS - feed_pos;
            closing_phase = (feed_pos + phase_len == ROW_WORDS);
            near_col = feed_pos / GROUP_WORDS + $urandom_range(0, 2);
            if (near_col > COLUMNS - 1 || $urandom_range(0, 1) == 0)
                near_col = $urandom_range(0, COLUMNS - 1);
            set_config(pick_pattern(), closing_phase ? 1'b0 : 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 2) == 0), COL_W'(near_col));
            repeat (phase_len) push_word(make_word(pick_kind(), cur_pattern));
            settle();
        end

        // Second row: half switched every four words so every word is checked and fully
        // flipped; the flip count passes the row's checked bit count and saturates
        for (int unsigned p = 0; p < SAT_WORDS; p++) begin
            if (p % WORDS_PER_READ == 0) begin
                if (p != 0)
                    settle();
                set_config(pick_pattern(), 1'((p / WORDS_PER_READ) % CHANNEL_HALVES), 1'b0,
                           COL_W'($urandom_range(0, COLUMNS - 1)));
            end
            push_word(~{8{cur_pattern}});
        end
        settle();

        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: row_readback_bitflip_locator.f
rtl/core/rrbl_pkg.sv
rtl/core/rrbl_datapath.sv
rtl/core/rrbl_ctrl.sv
rtl/core/row_readback_bitflip_locator.sv
tb/row_readback_bitflip_locator_checker.sv
tb/row_readback_bitflip_locator_test.sv
